### rtl/sfs_pkg.sv
// sfs_pkg: shared types and constants of the sprite frame sequencer
// used by the channel interfaces and by the top level; no dependencies
package sfs_pkg;

  localparam int ACTION_W    = 2;
  localparam int ID_W        = 4;
  localparam int US_W        = 16;
  localparam int SPRITE_W    = 16;
  localparam int FRAME_W     = 8;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int TABLE_SLOTS = 16;

  // accumulator in 1/SPEED_ONE us, scaled frame duration, shared unit widths
  localparam int ACC_W      = 34;
  localparam int DURS_W     = 33;
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 17;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_STEPS  = ACC_W;
  localparam int DIV_CNT_W  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP    = 1'd1;

  localparam logic [CFG_W-1:0] SPEED_RESET    = 16'd4096;
  localparam logic [CFG_W-1:0] MAX_STEP_RESET = 16'd50000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_PLAY   = 2'd1,
    ACT_DEFINE = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef struct packed {
    logic [SPRITE_W-1:0] start;
    logic [FRAME_W-1:0]  count;
    logic [US_W-1:0]     dur;
    logic                loop;
  } anim_entry_t;

endpackage

### rtl/sfs_chan_if.sv
// sfs_chan_if: valid/ready channels of the sprite frame sequencer
// depends on sfs_pkg for field widths
interface sfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfs_pkg::ACTION_W-1:0]  action;
  logic [sfs_pkg::ID_W-1:0]      anim_id;
  logic                          force_restart;
  logic [sfs_pkg::US_W-1:0]      elapsed_us;
  logic [sfs_pkg::SPRITE_W-1:0]  start_sprite;
  logic [sfs_pkg::FRAME_W-1:0]   frame_total;
  logic [sfs_pkg::US_W-1:0]      frame_time_us;
  logic                          loop_enable;

  modport source (
    output valid, action, anim_id, force_restart, elapsed_us, start_sprite,
           frame_total, frame_time_us, loop_enable,
    input  ready
  );
  modport sink (
    input  valid, action, anim_id, force_restart, elapsed_us, start_sprite,
           frame_total, frame_time_us, loop_enable,
    output ready
  );
endinterface

interface sfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [sfs_pkg::SPRITE_W-1:0]  sprite_id;
  logic [sfs_pkg::FRAME_W-1:0]   frame_now;
  logic [sfs_pkg::ID_W-1:0]      anim_now;
  logic                          done_res;

  modport source (
    output valid, sprite_id, frame_now, anim_now, done_res,
    input  ready
  );
  modport sink (
    input  valid, sprite_id, frame_now, anim_now, done_res,
    output ready
  );
endinterface

### rtl/sprite_frame_sequencer.sv
// sprite_frame_sequencer: animation table, frame timing and one shared multiplier and divider
// depends on sfs_pkg and the channel interfaces in sfs_chan_if
//
// usage:
//   item_in carries tick, play, define and no-op beats; res_out returns one beat per item
//   with the sprite id, frame, animation and finished flag after that item.
//   cfg_we_i/cfg_idx_i/cfg_data_i write speed_scale (index 0) and max_step_us (index 1);
//   write them only while the block is idle.
// steps:
//   play, define and no-op go from accept straight to the result register.
//   tick with no frame change: two passes through the multiplier, one compare.
//   tick that advances: the 34-step restoring divider runs after the compare; a looping
//   wrap runs the divider a second time, a clamp at the end multiplies again instead.
//   one item is in flight at a time; item_in.ready is high only when the sequencer idles.
// reset:
//   table entries, frame state and accumulator clear; speed_scale 4096, max_step_us 50000.
// stall:
//   the result register holds its beat while res_out.ready is low; the next item may be
//   accepted and worked on meanwhile, and its result waits until the register is free.
module sprite_frame_sequencer #(
  parameter int ANIMS     = 16,
  parameter int SPEED_ONE = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfs_pkg::CFG_W-1:0]       cfg_data_i,
  sfs_in_if.sink                          item_in,
  sfs_out_if.source                       res_out
);

  localparam int SLOTS  = (ANIMS < sfs_pkg::TABLE_SLOTS) ? ANIMS : sfs_pkg::TABLE_SLOTS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL1 = 9'b000000010,
    S_MUL2 = 9'b000000100,
    S_CMP  = 9'b000001000,
    S_DIV1 = 9'b000010000,
    S_ADV  = 9'b000100000,
    S_DIV2 = 9'b001000000,
    S_MUL3 = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  sfs_pkg::anim_entry_t              table_q [SLOTS];
  logic [sfs_pkg::ID_W-1:0]          cur_q;
  logic [sfs_pkg::FRAME_W-1:0]       frame_q;
  logic [sfs_pkg::ACC_W-1:0]         acc_q;
  logic                              fin_q;
  logic [sfs_pkg::CFG_W-1:0]         speed_q;
  logic [sfs_pkg::CFG_W-1:0]         max_step_q;

  logic [sfs_pkg::US_W-1:0]          el_q;
  logic [sfs_pkg::DURS_W-1:0]        durs_q;
  logic [sfs_pkg::FRAME_W-1:0]       te_q;
  logic [sfs_pkg::DURS_W-1:0]        rem_q;
  logic [sfs_pkg::ACC_W-1:0]         quo_q;
  logic [sfs_pkg::DURS_W-1:0]        div_q;
  logic [sfs_pkg::DIV_CNT_W-1:0]     cnt_q;

  logic                              out_valid_q;
  logic [sfs_pkg::SPRITE_W-1:0]      out_sprite_q;
  logic [sfs_pkg::FRAME_W-1:0]       out_frame_q;
  logic [sfs_pkg::ID_W-1:0]          out_anim_q;
  logic                              out_done_q;

  sfs_pkg::anim_entry_t              entry;
  sfs_pkg::action_e                  act;
  logic                              in_fire;
  logic                              id_ok;
  logic                              tick_live;
  logic                              play_hold;
  logic [sfs_pkg::US_W-1:0]          el_clamp;
  logic [sfs_pkg::MUL_A_W-1:0]       mul_a;
  logic [sfs_pkg::MUL_B_W-1:0]       mul_b;
  logic [sfs_pkg::MUL_P_W-1:0]       mul_p;
  logic [sfs_pkg::ACC_W-1:0]         div_r;
  logic [sfs_pkg::ACC_W-1:0]         div_diff;
  logic                              div_ge;
  logic [sfs_pkg::DURS_W-1:0]        div_rem;
  logic [sfs_pkg::FRAME_W-1:0]       to_end;
  logic                              short_step;
  logic                              res_load;

  assign entry     = table_q[cur_q[SLOT_W-1:0]];
  assign act       = sfs_pkg::action_e'(item_in.action);
  assign in_fire   = item_in.valid && item_in.ready;
  assign id_ok     = 32'(item_in.anim_id) < 32'(SLOTS);
  assign tick_live = !fin_q && (entry.count != '0) && (entry.dur != '0);
  assign play_hold = (cur_q == item_in.anim_id) && !item_in.force_restart && !fin_q;
  assign el_clamp  = (item_in.elapsed_us > max_step_q) ? max_step_q : item_in.elapsed_us;

  assign item_in.ready = (state_q == S_IDLE);
  assign res_load      = (state_q == S_DONE) && (!out_valid_q || res_out.ready);

  // shared multiplier: elapsed times speed, duration times one, frames to end times duration
  always_comb begin
    case (state_q)
      S_MUL1: begin
        mul_a = sfs_pkg::MUL_A_W'(el_q);
        mul_b = sfs_pkg::MUL_B_W'(speed_q);
      end
      S_MUL2: begin
        mul_a = sfs_pkg::MUL_A_W'(entry.dur);
        mul_b = sfs_pkg::MUL_B_W'(SPEED_ONE);
      end
      default: begin
        mul_a = durs_q;
        mul_b = sfs_pkg::MUL_B_W'(te_q);
      end
    endcase
  end
  assign mul_p = sfs_pkg::MUL_P_W'(mul_a) * sfs_pkg::MUL_P_W'(mul_b);

  // restoring divider step, one quotient bit a cycle
  assign div_r    = {rem_q, quo_q[sfs_pkg::ACC_W-1]};
  assign div_ge   = div_r >= sfs_pkg::ACC_W'(div_q);
  assign div_diff = div_r - sfs_pkg::ACC_W'(div_q);
  assign div_rem  = div_ge ? div_diff[sfs_pkg::DURS_W-1:0] : div_r[sfs_pkg::DURS_W-1:0];

  // frames left before the end; a frame past a shrunken count ends on the next advance
  always_comb begin
    if ((9'(frame_q) + 9'd1) >= 9'(entry.count)) begin
      to_end = sfs_pkg::FRAME_W'(1);
    end else begin
      to_end = entry.count - frame_q;
    end
  end
  assign short_step = quo_q < sfs_pkg::ACC_W'(to_end);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = ((act == sfs_pkg::ACT_TICK) && tick_live) ? S_MUL1 : S_DONE;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_CMP;
      S_CMP: begin
        state_d = (acc_q < sfs_pkg::ACC_W'(durs_q)) ? S_DONE : S_DIV1;
      end
      S_DIV1: begin
        if (cnt_q == sfs_pkg::DIV_CNT_W'(1)) state_d = S_ADV;
      end
      S_ADV: begin
        if (short_step) begin
          state_d = S_DONE;
        end else if (entry.loop) begin
          state_d = S_DIV2;
        end else begin
          state_d = S_MUL3;
        end
      end
      S_DIV2: begin
        if (cnt_q == sfs_pkg::DIV_CNT_W'(1)) state_d = S_DONE;
      end
      S_MUL3: state_d = S_DONE;
      S_DONE: begin
        if (res_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      frame_q     <= '0;
      acc_q       <= '0;
      fin_q       <= 1'b0;
      speed_q     <= sfs_pkg::SPEED_RESET;
      max_step_q  <= sfs_pkg::MAX_STEP_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        table_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfs_pkg::CFG_SPEED_SCALE: speed_q    <= cfg_data_i;
          sfs_pkg::CFG_MAX_STEP:    max_step_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (res_out.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (act)
              sfs_pkg::ACT_PLAY: begin
                if (id_ok && !play_hold) begin
                  cur_q   <= item_in.anim_id;
                  frame_q <= '0;
                  acc_q   <= '0;
                  fin_q   <= 1'b0;
                end
              end
              sfs_pkg::ACT_DEFINE: begin
                if (id_ok) begin
                  table_q[item_in.anim_id[SLOT_W-1:0]] <= '{
                    start: item_in.start_sprite,
                    count: item_in.frame_total,
                    dur:   item_in.frame_time_us,
                    loop:  item_in.loop_enable
                  };
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL1: acc_q <= acc_q + mul_p[sfs_pkg::ACC_W-1:0];
        S_CMP: begin
          if (acc_q >= sfs_pkg::ACC_W'(durs_q)) cnt_q <= sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_STEPS);
        end
        S_DIV1, S_DIV2: cnt_q <= cnt_q - sfs_pkg::DIV_CNT_W'(1);
        S_ADV: begin
          if (short_step) begin
            frame_q <= frame_q + quo_q[sfs_pkg::FRAME_W-1:0];
            acc_q   <= sfs_pkg::ACC_W'(rem_q);
          end else if (entry.loop) begin
            acc_q <= sfs_pkg::ACC_W'(rem_q);
            cnt_q <= sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_STEPS);
          end else begin
            frame_q <= entry.count - sfs_pkg::FRAME_W'(1);
            fin_q   <= 1'b1;
          end
        end
        S_DIV2: ;
        S_MUL3: acc_q <= acc_q - mul_p[sfs_pkg::ACC_W-1:0];
        default: ;
      endcase

      // the wrapped frame is the remainder of the second division
      if ((state_q == S_DIV2) && (cnt_q == sfs_pkg::DIV_CNT_W'(1))) begin
        frame_q <= div_rem[sfs_pkg::FRAME_W-1:0];
      end
    end
  end

  // datapath registers of the shared units and the result register
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: el_q <= el_clamp;
      S_MUL2: durs_q <= mul_p[sfs_pkg::DURS_W-1:0];
      S_CMP: begin
        quo_q <= acc_q;
        rem_q <= '0;
        div_q <= durs_q;
      end
      S_DIV1, S_DIV2: begin
        quo_q <= {quo_q[sfs_pkg::ACC_W-2:0], div_ge};
        rem_q <= div_rem;
      end
      S_ADV: begin
        te_q  <= to_end;
        quo_q <= quo_q - sfs_pkg::ACC_W'(to_end);
        rem_q <= '0;
        div_q <= sfs_pkg::DURS_W'(entry.count);
      end
      default: ;
    endcase

    if (res_load) begin
      out_sprite_q <= entry.start + sfs_pkg::SPRITE_W'(frame_q);
      out_frame_q  <= frame_q;
      out_anim_q   <= cur_q;
      out_done_q   <= fin_q;
    end
  end

  assign res_out.valid     = out_valid_q;
  assign res_out.sprite_id = out_sprite_q;
  assign res_out.frame_now = out_frame_q;
  assign res_out.anim_now  = out_anim_q;
  assign res_out.done_res  = out_done_q;

  // divider count runs only while a division is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> ((state_q == S_DIV1) || (state_q == S_DIV2)))
    else $error("divider count live outside a division");

  // an accepted beat always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("accepted beat not taken up by the sequencer");

  // a forced play of a valid id restarts at frame zero with a clear accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (act == sfs_pkg::ACT_PLAY) && item_in.force_restart && id_ok)
    |=> ((frame_q == '0) && (acc_q == '0) && !fin_q))
    else $error("forced play did not restart the animation");

  // the result register is loaded only when it is free or being drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_out.ready) |-> !res_load)
    else $error("result register overwritten while stalled");

endmodule

### tb/sv/sprite_frame_sequencer_tb.sv
// sprite_frame_sequencer_tb: self-checking testbench of the sprite frame sequencer
// drives define, play, tick and no-op beats, predicts every result beat and compares fields
// depends on sfs_pkg, the channel interfaces in sfs_chan_if and the sequencer top level
module sprite_frame_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT        = 26;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_CYCLES     = 300;
  localparam int CALM_FROM       = 900;
  localparam int CALM_TO         = 1100;
  localparam int TAIL_CYCLES     = 100;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int MAX_PRINTS      = 40;
  localparam longint unsigned SPEED_UNIT = 4096;

  typedef struct packed {
    sfs_pkg::action_e             act;
    logic [sfs_pkg::ID_W-1:0]     id;
    logic                         force_rs;
    logic [sfs_pkg::US_W-1:0]     elapsed;
    logic [sfs_pkg::SPRITE_W-1:0] start;
    logic [sfs_pkg::FRAME_W-1:0]  total;
    logic [sfs_pkg::US_W-1:0]     ftime;
    logic                         loop_en;
  } seq_item_t;

  typedef struct packed {
    logic [sfs_pkg::SPRITE_W-1:0] sprite;
    logic [sfs_pkg::FRAME_W-1:0]  frame;
    logic [sfs_pkg::ID_W-1:0]     anim;
    logic                         done;
  } frame_res_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [sfs_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [sfs_pkg::CFG_W-1:0]     cfg_data_i;

  sfs_in_if  in_ch ();
  sfs_out_if out_ch ();

  sprite_frame_sequencer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_in    (in_ch),
    .res_out    (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted sequencer state
  sfs_pkg::anim_entry_t        anim_tbl [sfs_pkg::TABLE_SLOTS];
  logic [sfs_pkg::ID_W-1:0]    cur_anim;
  logic [sfs_pkg::FRAME_W-1:0] cur_frame;
  longint unsigned             accum;
  logic                        done_flag;
  logic [sfs_pkg::CFG_W-1:0]   speed_reg;
  logic [sfs_pkg::CFG_W-1:0]   max_step_reg;

  seq_item_t  item_q [$];
  frame_res_t frame_exp_q [$];

  int  n_pushed, n_in, n_out, n_err, n_settings;
  int  n_tick, n_play, n_def, n_nop;
  int  idle_cycles, hold_left;
  bit  hold_done;
  bit  in_taken;
  seq_item_t  drive_item, seen_item;
  frame_res_t seen_res, want_res;

  function automatic seq_item_t mk_item(sfs_pkg::action_e act,
                                        logic [sfs_pkg::ID_W-1:0] id, logic force_rs,
                                        logic [sfs_pkg::US_W-1:0] elapsed,
                                        logic [sfs_pkg::SPRITE_W-1:0] start,
                                        logic [sfs_pkg::FRAME_W-1:0] total,
                                        logic [sfs_pkg::US_W-1:0] ftime,
                                        logic loop_en);
    seq_item_t it;
    it.act      = act;
    it.id       = id;
    it.force_rs = force_rs;
    it.elapsed  = elapsed;
    it.start    = start;
    it.total    = total;
    it.ftime    = ftime;
    it.loop_en  = loop_en;
    return it;
  endfunction

  // mostly short frames and small counts so that ticks keep advancing and wrapping
  function automatic seq_item_t random_item();
    int unsigned pick;
    int unsigned sel;
    seq_item_t   it;
    it = mk_item(sfs_pkg::ACT_NOP, sfs_pkg::ID_W'($urandom), 1'($urandom),
                 sfs_pkg::US_W'($urandom), sfs_pkg::SPRITE_W'($urandom),
                 sfs_pkg::FRAME_W'($urandom), sfs_pkg::US_W'($urandom), 1'($urandom));
    pick = $urandom_range(99);
    if (pick < 60) begin
      it.act = sfs_pkg::ACT_TICK;
      sel = $urandom_range(99);
      if (sel < 60) it.elapsed = sfs_pkg::US_W'($urandom_range(300));
      else if (sel < 85) it.elapsed = sfs_pkg::US_W'($urandom_range(5000));
    end else if (pick < 80) begin
      it.act = sfs_pkg::ACT_PLAY;
    end else if (pick < 98) begin
      it.act = sfs_pkg::ACT_DEFINE;
      sel = $urandom_range(99);
      if (sel < 30) it.total = sfs_pkg::FRAME_W'($urandom_range(4, 1));
      else if (sel < 70) it.total = sfs_pkg::FRAME_W'($urandom_range(16, 5));
      else if (sel < 80) it.total = '0;
      else if (sel < 90) it.total = '1;
      sel = $urandom_range(99);
      if (sel < 60) it.ftime = sfs_pkg::US_W'($urandom_range(200, 1));
      else if (sel < 80) it.ftime = sfs_pkg::US_W'($urandom_range(5000, 200));
      else if (sel < 90) it.ftime = '0;
    end
    return it;
  endfunction

  task automatic step_sequencer(input seq_item_t it, output frame_res_t r);
    sfs_pkg::anim_entry_t e;
    longint unsigned      el, dur, n, to_end, fr, cnt;
    e = anim_tbl[cur_anim];
    case (it.act)
      sfs_pkg::ACT_TICK: begin
        if (!done_flag && e.count != 0 && e.dur != 0) begin
          el = it.elapsed;
          if (el > max_step_reg) el = max_step_reg;
          accum += el * speed_reg;
          dur = e.dur * SPEED_UNIT;
          n = accum / dur;
          if (n != 0) begin
            fr  = cur_frame;
            cnt = e.count;
            // a frame left beyond a shrunken count counts as the last one
            to_end = (fr + 1 >= cnt) ? 1 : cnt - fr;
            if (n < to_end) begin
              cur_frame = sfs_pkg::FRAME_W'(fr + n);
              accum -= n * dur;
            end else if (e.loop) begin
              cur_frame = sfs_pkg::FRAME_W'((n - to_end) % cnt);
              accum -= n * dur;
            end else begin
              cur_frame = sfs_pkg::FRAME_W'(cnt - 1);
              done_flag = 1'b1;
              accum -= to_end * dur;
            end
          end
        end
      end
      sfs_pkg::ACT_PLAY: begin
        if (!(cur_anim == it.id && !it.force_rs && !done_flag)) begin
          cur_anim  = it.id;
          cur_frame = '0;
          accum     = 0;
          done_flag = 1'b0;
        end
      end
      sfs_pkg::ACT_DEFINE: begin
        anim_tbl[it.id].start = it.start;
        anim_tbl[it.id].count = it.total;
        anim_tbl[it.id].dur   = it.ftime;
        anim_tbl[it.id].loop  = it.loop_en;
      end
      default: ;
    endcase
    r.sprite = anim_tbl[cur_anim].start + sfs_pkg::SPRITE_W'(cur_frame);
    r.frame  = cur_frame;
    r.anim   = cur_anim;
    r.done   = done_flag;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (n_err < MAX_PRINTS)
      $display("tb: mismatch on %s at result %0d: got %0h, want %0h", what, n_out, got, want);
    n_err++;
  endtask

  // sender: holds a beat until it is taken, then maybe idles before the next one
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && !(in_ch.valid && !in_taken)) begin
      if (item_q.size() != 0 &&
          ((n_in >= CALM_FROM && n_in < CALM_TO) || $urandom_range(99) >= IDLE_PCT)) begin
        drive_item = item_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.action        <= drive_item.act;
        in_ch.anim_id       <= drive_item.id;
        in_ch.force_restart <= drive_item.force_rs;
        in_ch.elapsed_us    <= drive_item.elapsed;
        in_ch.start_sprite  <= drive_item.start;
        in_ch.frame_total   <= drive_item.total;
        in_ch.frame_time_us <= drive_item.ftime;
        in_ch.loop_enable   <= drive_item.loop_en;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the input side backs up
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && n_in >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_ch.ready <= (hold_left == 0) &&
                      ((n_in >= CALM_FROM && n_in < CALM_TO) || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        seen_item = mk_item(sfs_pkg::action_e'(in_ch.action), in_ch.anim_id,
                            in_ch.force_restart, in_ch.elapsed_us, in_ch.start_sprite,
                            in_ch.frame_total, in_ch.frame_time_us, in_ch.loop_enable);
        step_sequencer(seen_item, want_res);
        frame_exp_q.push_back(want_res);
        case (seen_item.act)
          sfs_pkg::ACT_TICK:   n_tick++;
          sfs_pkg::ACT_PLAY:   n_play++;
          sfs_pkg::ACT_DEFINE: n_def++;
          default:             n_nop++;
        endcase
        n_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (frame_exp_q.size() == 0) begin
          report_mismatch("unexpected result beat", out_ch.sprite_id, 0);
        end else begin
          seen_res = frame_exp_q.pop_front();
          if (out_ch.sprite_id !== seen_res.sprite)
            report_mismatch("sprite_id", out_ch.sprite_id, seen_res.sprite);
          if (out_ch.frame_now !== seen_res.frame)
            report_mismatch("frame_now", out_ch.frame_now, seen_res.frame);
          if (out_ch.anim_now !== seen_res.anim)
            report_mismatch("anim_now", out_ch.anim_now, seen_res.anim);
          if (out_ch.done_res !== seen_res.done)
            report_mismatch("done_res", out_ch.done_res, seen_res.done);
        end
        n_out++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("tb: watchdog expired with %0d results outstanding", frame_exp_q.size());
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (n_in != n_pushed || frame_exp_q.size() != 0);
  endtask

  task automatic write_regs(input logic [sfs_pkg::CFG_W-1:0] spd,
                            input logic [sfs_pkg::CFG_W-1:0] stp);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sfs_pkg::CFG_SPEED_SCALE;
    cfg_data_i <= spd;
    @(negedge clk_i);
    cfg_idx_i  <= sfs_pkg::CFG_MAX_STEP;
    cfg_data_i <= stp;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    speed_reg    = spd;
    max_step_reg = stp;
    n_settings++;
  endtask

  task automatic push_item(input seq_item_t it);
    item_q.push_back(it);
    n_pushed++;
  endtask

  initial begin : stim
    int p;
    logic [sfs_pkg::CFG_W-1:0] spd, stp;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = sfs_pkg::CFG_SPEED_SCALE;
    cfg_data_i = '0;
    in_ch.valid         = 1'b0;
    in_ch.action        = sfs_pkg::ACT_NOP;
    in_ch.anim_id       = '0;
    in_ch.force_restart = 1'b0;
    in_ch.elapsed_us    = '0;
    in_ch.start_sprite  = '0;
    in_ch.frame_total   = '0;
    in_ch.frame_time_us = '0;
    in_ch.loop_enable   = 1'b0;
    out_ch.ready        = 1'b0;
    for (int i = 0; i < sfs_pkg::TABLE_SLOTS; i++) anim_tbl[i] = '0;
    cur_anim     = '0;
    cur_frame    = '0;
    accum        = 0;
    done_flag    = 1'b0;
    speed_reg    = sfs_pkg::SPEED_RESET;
    max_step_reg = sfs_pkg::MAX_STEP_RESET;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // tick on an empty entry, sprite wrap, clamping of the step
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'd100,  16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_DEFINE, 4'd0,  1'b0, 16'd0,    16'hFFFE, 8'd3,  16'd1,    1'b1));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'd0,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'd1,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
    // largest entry, replay of the running animation is ignored
    push_item(mk_item(sfs_pkg::ACT_DEFINE, 4'd15, 1'b0, 16'd0,    16'hFFFF, 8'hFF, 16'hFFFF, 1'b0));
    push_item(mk_item(sfs_pkg::ACT_PLAY,   4'd15, 1'b0, 16'd0,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_PLAY,   4'd15, 1'b0, 16'd0,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'hFFFF, 16'd0,    8'd0,  16'd0,    1'b0));
    // non-looping run to the end, tick when finished, replay after finish and forced
    push_item(mk_item(sfs_pkg::ACT_DEFINE, 4'd1,  1'b0, 16'd0,    16'd100,  8'd4,  16'd10,   1'b0));
    push_item(mk_item(sfs_pkg::ACT_PLAY,   4'd1,  1'b0, 16'd0,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'd100,  16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'd5,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_PLAY,   4'd1,  1'b0, 16'd0,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_PLAY,   4'd1,  1'b1, 16'd0,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'd15,   16'd0,    8'd0,  16'd0,    1'b0));
    // shrink the running entry so the frame sits past the new count
    push_item(mk_item(sfs_pkg::ACT_DEFINE, 4'd1,  1'b0, 16'd0,    16'd100,  8'd1,  16'd10,   1'b1));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'd10,   16'd0,    8'd0,  16'd0,    1'b0));
    // zero frames, then zero duration
    push_item(mk_item(sfs_pkg::ACT_DEFINE, 4'd2,  1'b0, 16'd0,    16'd7,    8'd0,  16'd5,    1'b1));
    push_item(mk_item(sfs_pkg::ACT_PLAY,   4'd2,  1'b0, 16'd0,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'hFFFF, 16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_DEFINE, 4'd3,  1'b0, 16'd0,    16'd9,    8'd5,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_PLAY,   4'd3,  1'b0, 16'd0,    16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_TICK,   4'd0,  1'b0, 16'hFFFF, 16'd0,    8'd0,  16'd0,    1'b0));
    push_item(mk_item(sfs_pkg::ACT_NOP,    4'd15, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
    push_item(mk_item(sfs_pkg::ACT_PLAY,   4'd0,  1'b1, 16'd0,    16'd0,    8'd0,  16'd0,    1'b0));

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin spd = 16'd4096;  stp = 16'd50000; end
        1: begin spd = 16'd0;     stp = 16'hFFFF;  end
        2: begin spd = 16'hFFFF;  stp = 16'hFFFF;  end
        3: begin spd = 16'hFFFF;  stp = 16'd0;     end
        4: begin spd = 16'd1;     stp = 16'd1000;  end
        5: begin spd = 16'd8192;  stp = 16'd20000; end
        default: begin
          spd = sfs_pkg::CFG_W'($urandom);
          stp = sfs_pkg::CFG_W'($urandom);
        end
      endcase
      write_regs(spd, stp);
      repeat (ITEMS_PER_PHASE) push_item(random_item());
    end
    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("tb: %0d beats in (%0d tick, %0d play, %0d define, %0d no-op), %0d results checked",
             n_in, n_tick, n_play, n_def, n_nop, n_out);
    $display("tb: %0d register settings, one long result hold-off, %0d mismatches",
             n_settings, n_err);
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sfs_pkg.sv
rtl/sfs_chan_if.sv
rtl/sprite_frame_sequencer.sv
tb/sv/sprite_frame_sequencer_tb.sv
